// ----- hw/rtl/tod_pkg.sv -----
// Shared constants and field layout for the time-of-day parse and delay core.
package tod_pkg;

    // Field widths.
    localparam int CHAR_W   = 8;
    localparam int SEC_W    = 17;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 7;
    localparam int DIGIT_W  = 4;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FMT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NOW   = 2'd3;

    // Time constants.
    localparam logic [SEC_W-1:0]   SECS_PER_DAY  = 17'd86400;
    localparam logic [SEC_W-1:0]   SECS_PER_HOUR = 17'd3600;
    localparam logic [SEC_W-1:0]   SECS_PER_MIN  = 17'd60;
    localparam logic [VALUE_W-1:0] HOUR_MAX      = 7'd23;
    localparam logic [VALUE_W-1:0] MINSEC_MAX    = 7'd59;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

endpackage

// ----- hw/rtl/time_of_day_parse_and_delay_core.sv -----
// Time-of-day string parser: collects H[H]:MM[:SS] and reports target second and delay.
// A terminating NUL item moves from the input register into the result register, which
// drives m_tdata; it waits in the input register while the result register is not free.
// Throughput: one character per cycle; the input register and result register keep both
// sides moving, and only a NUL item waits on a full result register that is not drained.
// Reset: aresetn is synchronous and active low; it empties both registers and returns
// the parser to the start of a string with hour, minute and second cleared.
module time_of_day_parse_and_delay_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Fields from bit 0 up: char_code[7:0], now_seconds[24:8], zero pad[31:25].
    input  logic [tod_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: status[1:0], target_seconds[18:2], delay_seconds[35:19],
    // zero pad[39:36].
    output logic [tod_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    // Parse phase codes.
    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_HOUR1    = 4'd1;
    localparam logic [3:0] PH_HOUR2    = 4'd2;
    localparam logic [3:0] PH_MIN0     = 4'd3;
    localparam logic [3:0] PH_MIN1     = 4'd4;
    localparam logic [3:0] PH_MIN_DONE = 4'd5;
    localparam logic [3:0] PH_SEC0     = 4'd6;
    localparam logic [3:0] PH_SEC1     = 4'd7;
    localparam logic [3:0] PH_SEC_DONE = 4'd8;
    localparam logic [3:0] PH_ERROR    = 4'd9;

    // Input register.
    logic                         in_valid_reg;
    logic [tod_pkg::CHAR_W-1:0]   in_char_reg;
    logic [tod_pkg::SEC_W-1:0]    in_now_reg;

    // Parser state.
    logic [3:0]                   phase_reg, phase_next;
    logic [tod_pkg::VALUE_W-1:0]  hour_reg, hour_next;
    logic [tod_pkg::VALUE_W-1:0]  minute_reg, minute_next;
    logic [tod_pkg::VALUE_W-1:0]  second_reg, second_next;

    // Result register.
    logic                         out_valid_reg;
    logic [tod_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tod_pkg::SEC_W-1:0]    target_reg, target_next;
    logic [tod_pkg::SEC_W-1:0]    delay_reg, delay_next;

    logic                         out_free;
    logic                         in_is_nul;
    logic                         work_fire;
    logic                         is_dig;
    logic                         is_colon;
    logic [tod_pkg::DIGIT_W-1:0]  digit;
    logic [tod_pkg::VALUE_W-1:0]  digit_ext;
    logic [tod_pkg::SEC_W-1:0]    target_sum;
    logic                         phase_done;
    logic                         in_range;

    // Handshake: a held item moves on when it needs no result slot or the slot frees up.
    assign out_free  = !out_valid_reg || m_tready;
    assign in_is_nul = (in_char_reg == tod_pkg::CHAR_NUL);
    assign work_fire = in_valid_reg && (!in_is_nul || out_free);
    assign s_tready  = !in_valid_reg || work_fire;

    // Character classification.
    assign is_dig    = (in_char_reg >= tod_pkg::CHAR_ZERO) && (in_char_reg <= tod_pkg::CHAR_NINE);
    assign is_colon  = (in_char_reg == tod_pkg::CHAR_COLON);
    assign digit     = tod_pkg::DIGIT_W'(in_char_reg - tod_pkg::CHAR_ZERO);
    assign digit_ext = {{(tod_pkg::VALUE_W - tod_pkg::DIGIT_W){1'b0}}, digit};

    // Phase machine for the H[H]:MM[:SS] form; digits are accumulated modulo 128.
    always_comb begin
        phase_next  = PH_ERROR;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        unique case (phase_reg)
            PH_START: begin
                if (is_dig) begin
                    hour_next  = digit_ext;
                    phase_next = PH_HOUR1;
                end
            end
            PH_HOUR1: begin
                if (is_dig) begin
                    hour_next  = tod_pkg::VALUE_W'(hour_reg * 7'd10 + digit_ext);
                    phase_next = PH_HOUR2;
                end else if (is_colon) begin
                    phase_next = PH_MIN0;
                end
            end
            PH_HOUR2: begin
                if (is_colon) begin
                    phase_next = PH_MIN0;
                end
            end
            PH_MIN0: begin
                if (is_dig) begin
                    minute_next = digit_ext;
                    phase_next  = PH_MIN1;
                end
            end
            PH_MIN1: begin
                if (is_dig) begin
                    minute_next = tod_pkg::VALUE_W'(minute_reg * 7'd10 + digit_ext);
                    phase_next  = PH_MIN_DONE;
                end
            end
            PH_MIN_DONE: begin
                if (is_colon) begin
                    phase_next = PH_SEC0;
                end
            end
            PH_SEC0: begin
                if (is_dig) begin
                    second_next = digit_ext;
                    phase_next  = PH_SEC1;
                end
            end
            PH_SEC1: begin
                if (is_dig) begin
                    second_next = tod_pkg::VALUE_W'(second_reg * 7'd10 + digit_ext);
                    phase_next  = PH_SEC_DONE;
                end
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Result for the terminating item, with the current-time check taking priority.
    assign phase_done = (phase_reg == PH_MIN_DONE) || (phase_reg == PH_SEC_DONE);
    assign in_range   = (hour_reg <= tod_pkg::HOUR_MAX) && (minute_reg <= tod_pkg::MINSEC_MAX)
                        && (second_reg <= tod_pkg::MINSEC_MAX);
    assign target_sum = tod_pkg::SEC_W'(
                          {{(tod_pkg::SEC_W - tod_pkg::VALUE_W){1'b0}}, hour_reg}
                              * tod_pkg::SECS_PER_HOUR
                        + {{(tod_pkg::SEC_W - tod_pkg::VALUE_W){1'b0}}, minute_reg}
                              * tod_pkg::SECS_PER_MIN
                        + {{(tod_pkg::SEC_W - tod_pkg::VALUE_W){1'b0}}, second_reg});

    always_comb begin
        status_next = tod_pkg::STATUS_OK;
        target_next = '0;
        delay_next  = '0;
        if (in_now_reg >= tod_pkg::SECS_PER_DAY) begin
            status_next = tod_pkg::STATUS_BAD_NOW;
        end else if (!phase_done) begin
            status_next = tod_pkg::STATUS_BAD_FMT;
        end else if (!in_range) begin
            status_next = tod_pkg::STATUS_RANGE;
        end else begin
            target_next = target_sum;
            // The wrapped form stays below one day, so 17-bit wraparound gives it exactly.
            if (target_sum >= in_now_reg) begin
                delay_next = target_sum - in_now_reg;
            end else begin
                delay_next = target_sum - in_now_reg + tod_pkg::SECS_PER_DAY;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[tod_pkg::CHAR_W-1:0];
            in_now_reg  <= s_tdata[tod_pkg::CHAR_W +: tod_pkg::SEC_W];
        end
    end

    // Parser state: advances on characters, returns to the start after each NUL.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end else if (work_fire) begin
            if (in_is_nul) begin
                phase_reg  <= PH_START;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
            end else begin
                phase_reg  <= phase_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= work_fire && in_is_nul;
        end
    end

    always_ff @(posedge aclk) begin
        if (work_fire && in_is_nul) begin
            status_reg <= status_next;
            target_reg <= target_next;
            delay_reg  <= delay_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, delay_reg, target_reg, status_reg};

endmodule

// ----- hw/rtl/tod_checker.sv -----
// Port-level checker for the time-of-day core, bound to the top level.
module tod_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [tod_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready
);

    logic [tod_pkg::STATUS_W-1:0] status;
    logic [tod_pkg::SEC_W-1:0]    target;
    logic [tod_pkg::SEC_W-1:0]    delay;

    assign status = m_tdata[tod_pkg::STATUS_W-1:0];
    assign target = m_tdata[tod_pkg::STATUS_W +: tod_pkg::SEC_W];
    assign delay  = m_tdata[tod_pkg::STATUS_W + tod_pkg::SEC_W +: tod_pkg::SEC_W];

    // A pending result stays put until its transfer completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The input only stalls behind a terminating item while the result register is blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    // A good result lies within one day.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == tod_pkg::STATUS_OK |->
            target < tod_pkg::SECS_PER_DAY && delay < tod_pkg::SECS_PER_DAY)
        else $error("target or delay beyond one day");

    // An error result carries zero target and delay, and no pad bits are set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status != tod_pkg::STATUS_OK |->
            target == '0 && delay == '0 && m_tdata[tod_pkg::M_DATA_W-1:36] == '0)
        else $error("error result with nonzero payload");

endmodule

bind time_of_day_parse_and_delay_core tod_checker u_tod_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- dv/tb_time_of_day_parse_and_delay_core.sv -----
// Self-checking testbench for the time-of-day parse and delay core.
module tb_time_of_day_parse_and_delay_core;

    localparam int TARGET_ITEMS   = 1150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 500;
    localparam int DRAIN_CYCLES   = 8;

    // Parse phases of the character machine.
    typedef enum logic [3:0] {
        PH_START, PH_HOUR1, PH_HOUR2, PH_MIN0, PH_MIN1,
        PH_MIN_DONE, PH_SEC0, PH_SEC1, PH_SEC_DONE, PH_ERROR
    } tod_phase_t;

    typedef struct packed {
        logic [tod_pkg::STATUS_W-1:0] status;
        logic [tod_pkg::SEC_W-1:0]    target;
        logic [tod_pkg::SEC_W-1:0]    delay;
    } tod_result_t;

    typedef struct {
        logic [tod_pkg::CHAR_W-1:0] ch;
        logic [tod_pkg::SEC_W-1:0]  now;
        bit                         typed;
        tod_result_t                res;
    } stim_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic [tod_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tod_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    // Predictor state, mirrors the parser inside the block.
    tod_phase_t                  cur_phase  = PH_START;
    logic [tod_pkg::VALUE_W-1:0] hour_acc   = '0;
    logic [tod_pkg::VALUE_W-1:0] minute_acc = '0;
    logic [tod_pkg::VALUE_W-1:0] second_acc = '0;

    tod_result_t pending_results[$];
    stim_row_t   directed_rows[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    time_of_day_parse_and_delay_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Advances the parser by one character; a NUL character yields the time result.
    task automatic parse_time_char(input logic [tod_pkg::CHAR_W-1:0] ch,
                                   input logic [tod_pkg::SEC_W-1:0] now,
                                   output bit has_result, output tod_result_t res);
        bit         is_dig;
        bit         is_colon;
        logic [3:0] digit;
        tod_phase_t nxt;
        int         acc;
        int         tgt;
        has_result = 1'b0;
        res        = '0;
        if (ch != tod_pkg::CHAR_NUL) begin
            is_dig   = (ch >= tod_pkg::CHAR_ZERO) && (ch <= tod_pkg::CHAR_NINE);
            is_colon = (ch == tod_pkg::CHAR_COLON);
            digit    = ch[3:0];
            nxt      = PH_ERROR;
            case (cur_phase)
                PH_START: begin
                    if (is_dig) begin
                        hour_acc = tod_pkg::VALUE_W'(digit);
                        nxt = PH_HOUR1;
                    end
                end
                PH_HOUR1: begin
                    if (is_dig) begin
                        acc = hour_acc * 10 + digit;
                        hour_acc = acc[tod_pkg::VALUE_W-1:0];
                        nxt = PH_HOUR2;
                    end else if (is_colon) begin
                        nxt = PH_MIN0;
                    end
                end
                PH_HOUR2:    if (is_colon) nxt = PH_MIN0;
                PH_MIN0: begin
                    if (is_dig) begin
                        minute_acc = tod_pkg::VALUE_W'(digit);
                        nxt = PH_MIN1;
                    end
                end
                PH_MIN1: begin
                    if (is_dig) begin
                        acc = minute_acc * 10 + digit;
                        minute_acc = acc[tod_pkg::VALUE_W-1:0];
                        nxt = PH_MIN_DONE;
                    end
                end
                PH_MIN_DONE: if (is_colon) nxt = PH_SEC0;
                PH_SEC0: begin
                    if (is_dig) begin
                        second_acc = tod_pkg::VALUE_W'(digit);
                        nxt = PH_SEC1;
                    end
                end
                PH_SEC1: begin
                    if (is_dig) begin
                        acc = second_acc * 10 + digit;
                        second_acc = acc[tod_pkg::VALUE_W-1:0];
                        nxt = PH_SEC_DONE;
                    end
                end
                default: nxt = PH_ERROR;
            endcase
            cur_phase = nxt;
        end else begin
            has_result = 1'b1;
            if (now >= tod_pkg::SECS_PER_DAY) begin
                res.status = tod_pkg::STATUS_BAD_NOW;
            end else if (cur_phase != PH_MIN_DONE && cur_phase != PH_SEC_DONE) begin
                res.status = tod_pkg::STATUS_BAD_FMT;
            end else if (hour_acc > tod_pkg::HOUR_MAX || minute_acc > tod_pkg::MINSEC_MAX ||
                         second_acc > tod_pkg::MINSEC_MAX) begin
                res.status = tod_pkg::STATUS_RANGE;
            end else begin
                tgt = hour_acc * 3600 + minute_acc * 60 + second_acc;
                res.status = tod_pkg::STATUS_OK;
                res.target = tod_pkg::SEC_W'(tgt);
                if (tgt >= int'(now))
                    res.delay = tod_pkg::SEC_W'(tgt - int'(now));
                else
                    res.delay = tod_pkg::SEC_W'(int'(tod_pkg::SECS_PER_DAY) - int'(now) + tgt);
            end
            // Every string end returns the parser to its idle state.
            cur_phase  = PH_START;
            hour_acc   = '0;
            minute_acc = '0;
            second_acc = '0;
        end
    endtask

    // Offers one character in bursts with random gaps; called and returns at a falling edge.
    task automatic send_item(input logic [tod_pkg::CHAR_W-1:0] ch,
                             input logic [tod_pkg::SEC_W-1:0] now,
                             input bit typed, input tod_result_t typed_res);
        int          gap;
        bit          has_res;
        tod_result_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {{(tod_pkg::S_DATA_W - tod_pkg::CHAR_W - tod_pkg::SEC_W){1'b0}}, now, ch};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        parse_time_char(ch, now, has_res, res);
        if (has_res)
            pending_results.push_back(typed ? typed_res : res);
        @(negedge aclk);
    endtask

    function automatic logic [tod_pkg::CHAR_W-1:0] odd_char();
        logic [tod_pkg::CHAR_W-1:0] picks[8] = '{8'h2F, 8'h3A, 8'h3B, 8'h30,
                                                 8'h39, 8'h01, 8'h80, 8'hFF};
        if ($urandom_range(0, 1) == 0)
            return picks[$urandom_range(0, 7)];
        return tod_pkg::CHAR_W'($urandom_range(1, 255));
    endfunction

    // Builds one time string, mostly well formed, sometimes broken or pure noise.
    task automatic send_random_string();
        logic [tod_pkg::CHAR_W-1:0] chars[$];
        logic [tod_pkg::SEC_W-1:0]  now;
        tod_result_t                unused;
        int kind, hr, mn, sc, tgt, pos, pick;
        bit with_sec;
        logic [tod_pkg::SEC_W-1:0] now_edges[5] = '{17'd0, 17'd1, 17'd86399,
                                                    17'd86400, 17'd131071};
        unused = '0;
        kind = $urandom_range(0, 99);
        hr = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 99);
        mn = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        sc = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        with_sec = $urandom_range(0, 1);
        if (kind < 85) begin
            if (hr >= 10 || $urandom_range(0, 1) == 0)
                chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(hr / 10));
            chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(hr % 10));
            chars.push_back(tod_pkg::CHAR_COLON);
            chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(mn / 10));
            chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(mn % 10));
            if (with_sec) begin
                chars.push_back(tod_pkg::CHAR_COLON);
                chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(sc / 10));
                chars.push_back(tod_pkg::CHAR_ZERO + tod_pkg::CHAR_W'(sc % 10));
            end
            // Broken strings: cut short, one character replaced, or one inserted.
            if (kind >= 70) begin
                pick = $urandom_range(0, 2);
                pos  = $urandom_range(0, chars.size() - 1);
                if (pick == 0) begin
                    while (chars.size() > pos) void'(chars.pop_back());
                end else if (pick == 1) begin
                    chars[pos] = odd_char();
                end else begin
                    chars.insert(pos, odd_char());
                end
            end
        end else begin
            repeat ($urandom_range(0, 6))
                chars.push_back(tod_pkg::CHAR_W'($urandom_range(1, 255)));
        end
        foreach (chars[i])
            send_item(chars[i], tod_pkg::SEC_W'($urandom_range(0, 131071)), 1'b0, unused);
        // The current time is mostly valid, sometimes equal to the target, at its limits or past one day.
        tgt  = (hr * 3600 + mn * 60 + (with_sec ? sc : 0)) % 86400;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            now = tod_pkg::SEC_W'(tgt);
        else if (pick < 14)
            now = now_edges[$urandom_range(0, 4)];
        else if (pick < 24)
            now = tod_pkg::SEC_W'($urandom_range(86400, 131071));
        else
            now = tod_pkg::SEC_W'($urandom_range(0, 86399));
        send_item(tod_pkg::CHAR_NUL, now, 1'b0, unused);
    endtask

    function automatic void add_char(input logic [tod_pkg::CHAR_W-1:0] ch);
        stim_row_t row;
        row.ch    = ch;
        row.now   = '0;
        row.typed = 1'b0;
        row.res   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_end(input logic [tod_pkg::SEC_W-1:0] now, input bit typed,
                                    input logic [tod_pkg::STATUS_W-1:0] st,
                                    input logic [tod_pkg::SEC_W-1:0] tgt,
                                    input logic [tod_pkg::SEC_W-1:0] dly);
        stim_row_t row;
        row.ch    = tod_pkg::CHAR_NUL;
        row.now   = now;
        row.typed = typed;
        row.res   = '{status: st, target: tgt, delay: dly};
        directed_rows.push_back(row);
    endfunction

    // Main sequence: reset, directed table, random strings, drain and verdict.
    initial begin
        // Empty string.
        add_end(17'd0, 1'b1, tod_pkg::STATUS_BAD_FMT, 17'd0, 17'd0);
        // Single hour digit, earliest time of day.
        add_char(tod_pkg::CHAR_ZERO); add_char(tod_pkg::CHAR_COLON);
        add_char(tod_pkg::CHAR_ZERO); add_char(tod_pkg::CHAR_ZERO);
        add_end(17'd0, 1'b1, tod_pkg::STATUS_OK, 17'd0, 17'd0);
        // Latest time of day with seconds.
        add_char(tod_pkg::CHAR_ZERO + 8'd2); add_char(tod_pkg::CHAR_ZERO + 8'd3);
        add_char(tod_pkg::CHAR_COLON);
        add_char(tod_pkg::CHAR_ZERO + 8'd5); add_char(tod_pkg::CHAR_ZERO + 8'd9);
        add_char(tod_pkg::CHAR_COLON);
        add_char(tod_pkg::CHAR_ZERO + 8'd5); add_char(tod_pkg::CHAR_ZERO + 8'd9);
        add_end(17'd0, 1'b1, tod_pkg::STATUS_OK, 17'd86399, 17'd86399);
        // Malformed string with an invalid clock: the clock error wins.
        add_char(tod_pkg::CHAR_COLON);
        add_end(17'd131071, 1'b1, tod_pkg::STATUS_BAD_NOW, 17'd0, 17'd0);
        // Minutes out of range.
        add_char(tod_pkg::CHAR_ZERO + 8'd9); add_char(tod_pkg::CHAR_COLON);
        add_char(tod_pkg::CHAR_ZERO + 8'd9); add_char(tod_pkg::CHAR_ZERO + 8'd9);
        add_end(17'd86399, 1'b1, tod_pkg::STATUS_RANGE, 17'd0, 17'd0);
        // String ending right after the colon.
        add_char(tod_pkg::CHAR_ZERO + 8'd1); add_char(tod_pkg::CHAR_COLON);
        add_end(17'd5, 1'b1, tod_pkg::STATUS_BAD_FMT, 17'd0, 17'd0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].ch, directed_rows[i].now, directed_rows[i].typed,
                      directed_rows[i].res);
        while (items_sent < TARGET_ITEMS)
            send_random_string();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters and checked %0d results after a long output stall.",
                 items_sent, results_seen);
        $display("Status mix: ok %0d, bad format %0d, out of range %0d, bad clock %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: stall modes that change at random, plus one long hold-off.
    initial begin : result_ready_gen
        int  mode;
        int  mode_left;
        int  tick;
        bit  held;
        mode = 0;
        mode_left = 0;
        tick = 0;
        held = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            tick++;
            if (!held && items_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 3) == 0);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest pending expectation.
    always @(posedge aclk) begin : result_check
        tod_result_t got;
        tod_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[tod_pkg::STATUS_W-1:0];
            got.target = m_tdata[tod_pkg::STATUS_W +: tod_pkg::SEC_W];
            got.delay  = m_tdata[tod_pkg::STATUS_W + tod_pkg::SEC_W +: tod_pkg::SEC_W];
            results_seen++;
            status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("pending results for an unexpected transfer", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status of result %0d", results_seen),
                                    want.status, got.status);
                if (got.target !== want.target)
                    report_mismatch($sformatf("target of result %0d", results_seen),
                                    want.target, got.target);
                if (got.delay !== want.delay)
                    report_mismatch($sformatf("delay of result %0d", results_seen),
                                    want.delay, got.delay);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d results still pending", pending_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
